>>> rtl/mlp221_pkg.sv
// Shared types, constants and arithmetic helpers for the 2-2-1 sigmoid network trainer.
// Holds the sigmoid lookup table, rounding and saturation helpers and sequencer step codes.
// No dependencies.
`default_nettype none

package mlp221_pkg;

   localparam int SIGMOID_ENTRIES = 256;
   localparam int FRACTION_BITS   = 12;
   localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);
   localparam int UNIT            = 1 << FRACTION_BITS;
   localparam int SH_ONE          = FRACTION_BITS;
   localparam int SH_LOSS         = FRACTION_BITS + 1;
   localparam int SH_TWO          = 2 * FRACTION_BITS;

   // Datapath widths
   localparam int ACC_W = 48;
   localparam int OPA_W = 27;
   localparam int OPB_W = 17;

   // Actions; code three behaves as infer only
   localparam logic [1:0] ACT_LOAD     = 2'd0;
   localparam logic [1:0] ACT_INFER    = 2'd1;
   localparam logic [1:0] ACT_TRAIN    = 2'd2;
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   // Sequencer steps: forward pass, loss, output delta, backward pass, updates
   localparam logic [4:0] ST_H0_X0   = 5'd0;
   localparam logic [4:0] ST_H0_X1   = 5'd1;
   localparam logic [4:0] ST_H0_B    = 5'd2;
   localparam logic [4:0] ST_H1_X0   = 5'd3;
   localparam logic [4:0] ST_H1_X1   = 5'd4;
   localparam logic [4:0] ST_H1_B    = 5'd5;
   localparam logic [4:0] ST_Y_H0    = 5'd6;
   localparam logic [4:0] ST_Y_H1    = 5'd7;
   localparam logic [4:0] ST_Y_B     = 5'd8;
   localparam logic [4:0] ST_Y_ACT   = 5'd9;
   localparam logic [4:0] ST_LOSS    = 5'd10;
   localparam logic [4:0] ST_DY      = 5'd11;
   localparam logic [4:0] ST_DYY     = 5'd12;
   localparam logic [4:0] ST_DOUT    = 5'd13;
   localparam logic [4:0] ST_WD0     = 5'd14;
   localparam logic [4:0] ST_LRDO    = 5'd15;
   localparam logic [4:0] ST_DH0_A   = 5'd16;
   localparam logic [4:0] ST_DH0_B   = 5'd17;
   localparam logic [4:0] ST_WD1     = 5'd18;
   localparam logic [4:0] ST_UWO0    = 5'd19;
   localparam logic [4:0] ST_DH1_A   = 5'd20;
   localparam logic [4:0] ST_DH1_B   = 5'd21;
   localparam logic [4:0] ST_UWO1    = 5'd22;
   localparam logic [4:0] ST_LRDH0   = 5'd23;
   localparam logic [4:0] ST_BH0     = 5'd24;
   localparam logic [4:0] ST_UWH0    = 5'd25;
   localparam logic [4:0] ST_UWH2    = 5'd26;
   localparam logic [4:0] ST_LRDH1   = 5'd27;
   localparam logic [4:0] ST_BH1     = 5'd28;
   localparam logic [4:0] ST_UWH1    = 5'd29;
   localparam logic [4:0] ST_UWH3    = 5'd30;
   localparam logic [4:0] ST_LAST    = 5'd31;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic enable;
      logic accumulate;
   } mac_ctrl_type;

   typedef logic [12:0] sig_table_type [SIGMOID_ENTRIES];

   // Long division by shift and subtract
   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((num >> i) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   // Build the sigmoid table at elaboration: exp(-|x|) by Taylor series and repeated squaring
   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      longint unsigned one;
      longint unsigned mid;
      longint unsigned p;
      longint unsigned m;
      longint unsigned a;
      longint unsigned u;
      longint unsigned t2;
      longint unsigned t3;
      longint unsigned t4;
      longint unsigned e;
      longint unsigned den;
      longint unsigned num;
      logic            pos;
      one = 64'd1 << 30;
      mid = 64'd1 << 39;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         p   = ((64'(2 * k + 1)) << 39) / SIGMOID_ENTRIES;
         pos = (p >= mid);
         m   = pos ? p - mid : mid - p;
         a   = m >> FRACTION_BITS;
         u   = (a >> 10) << 6;
         t2  = (u * u) >> 30;
         t3  = (t2 * u) >> 30;
         t4  = (t3 * u) >> 30;
         e   = (one + (t2 >> 1) + udiv64(t4, 64'd24)) - u - udiv64(t3, 64'd6);
         for (int r = 0; r < 10; r++) begin
            e = (e * e + (one >> 1)) >> 30;
         end
         den = one + e;
         num = pos ? ((64'd1 << FRACTION_BITS) << 30) : (e << FRACTION_BITS);
         tbl[k] = 13'(udiv64(num + (den >> 1), den));
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   // Round half away from zero, dropping s fraction bits
   function automatic logic signed [ACC_W-1:0] rnd(logic signed [ACC_W-1:0] v, int s);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] mag;
      half = ACC_W'(1) <<< (s - 1);
      if (v >= 0) begin
         return (v + half) >>> s;
      end
      mag = -v;
      return -((mag + half) >>> s);
   endfunction

   // Saturate to a signed 16-bit word
   function automatic logic signed [15:0] sat16(logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(32767)) begin
         return 16'sh7FFF;
      end
      if (v < -ACC_W'(32768)) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Sigmoid lookup of a saturated pre-activation word
   function automatic logic [12:0] sigm(logic signed [15:0] s);
      logic [15:0]          biased;
      logic [16+SIG_IDX_W:0] scaled;
      biased = {~s[15], s[14:0]};
      scaled = (17+SIG_IDX_W)'(biased) * (17+SIG_IDX_W)'(SIGMOID_ENTRIES);
      return SIG_TABLE[scaled[15+SIG_IDX_W:16]];
   endfunction

endpackage

`default_nettype wire

>>> rtl/mlp221_mac.sv
// Shared multiply-accumulate unit of the network trainer.
// Depends on mlp221_pkg for widths and the control struct.
`default_nettype none

module mlp221_mac (
   input  wire logic                                  clock,
   input  wire mlp221_pkg::mac_ctrl_type              ctrl,
   input  wire logic signed [mlp221_pkg::OPA_W-1:0]   op_a,
   input  wire logic signed [mlp221_pkg::OPB_W-1:0]   op_b,
   output logic signed [mlp221_pkg::ACC_W-1:0]        acc
);

   localparam int PROD_W = mlp221_pkg::OPA_W + mlp221_pkg::OPB_W;

   logic signed [PROD_W-1:0]              prod;
   logic signed [mlp221_pkg::ACC_W-1:0]   acc_ff;
   logic signed [mlp221_pkg::ACC_W-1:0]   acc_in;

   // Multiply, then add to the running sum or start a new one
   always_comb begin
      prod   = op_a * op_b;
      acc_in = (ctrl.accumulate ? acc_ff : '0) + mlp221_pkg::ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

>>> rtl/mlp_two_two_one_sgd_train.sv
// Top level of the 2-2-1 sigmoid network with one-step gradient descent training.
// Depends on mlp221_pkg and mlp221_mac.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------------
//   request | start, busy, req_*                      | taken when start & !busy
//   result  | rsp_strobe, rsp_prediction, rsp_error_* | one-cycle strobe, no stall
//   csr     | csr_valid, csr_ready, csr_data          | taken when valid & ready
//
// A load transaction returns its result in the cycle after acceptance.
// Infer and train keep busy high while their steps run, all through the one shared
// multiply-accumulate unit, so the next transaction is taken only once busy falls.
// The result is strobed after the loss step; train keeps busy high for the weight
// updates that follow. Reset is synchronous and clears all weights and sets the
// learning rate to 410. The receiver cannot stall the result.
`default_nettype none

module mlp_two_two_one_sgd_train (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [15:0] req_input_a,
   input  wire logic signed [15:0] req_input_b,
   input  wire logic               req_target,
   input  wire logic [3:0]         req_weight_index,
   input  wire logic signed [15:0] req_weight_value,
   output logic                    rsp_strobe,
   output logic [12:0]             rsp_prediction,
   output logic [11:0]             rsp_error_loss,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [12:0]        csr_data
);

   localparam int ACC_W = mlp221_pkg::ACC_W;
   localparam int OPA_W = mlp221_pkg::OPA_W;
   localparam int OPB_W = mlp221_pkg::OPB_W;

   mlp221_pkg::seq_state_type state_ff;
   logic [4:0]                step_ff;
   logic                      train_ff;
   logic [12:0]               lr_ff;

   logic signed [15:0]        wh_ff [4];
   logic signed [15:0]        bh_ff [2];
   logic signed [15:0]        wo_ff [2];
   logic signed [15:0]        bo_ff;

   logic signed [15:0]        x0_ff;
   logic signed [15:0]        x1_ff;
   logic                      t_ff;
   logic [12:0]               h0_ff;
   logic [12:0]               h1_ff;
   logic [12:0]               y_ff;
   logic signed [15:0]        dout_ff;
   logic signed [15:0]        wd_ff;
   logic signed [15:0]        dh0_ff;
   logic signed [15:0]        dh1_ff;
   logic signed [OPA_W-1:0]   lrd_ff;

   logic                      rsp_strobe_ff;
   logic [12:0]               rsp_prediction_ff;
   logic [11:0]               rsp_error_loss_ff;

   logic                      accept;
   logic signed [13:0]        d_w;
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-1:0]   acc_r1;
   logic signed [ACC_W-1:0]   acc_r2;
   logic signed [ACC_W-1:0]   acc_rl;
   logic [12:0]               acc_sig;
   logic signed [OPA_W-1:0]   op_a;
   logic signed [OPB_W-1:0]   op_b;
   mlp221_pkg::mac_ctrl_type  mac_ctrl;

   assign accept    = start && (state_ff == mlp221_pkg::SEQ_IDLE);
   assign busy      = (state_ff == mlp221_pkg::SEQ_RUN);
   assign csr_ready = 1'b1;

   // Error term and rounded views of the accumulator
   always_comb begin
      d_w     = 14'($signed({1'b0, y_ff})) - (t_ff ? 14'(mlp221_pkg::UNIT) : 14'sd0);
      acc_r1  = mlp221_pkg::rnd(acc, mlp221_pkg::SH_ONE);
      acc_r2  = mlp221_pkg::rnd(acc, mlp221_pkg::SH_TWO);
      acc_rl  = mlp221_pkg::rnd(acc, mlp221_pkg::SH_LOSS);
      acc_sig = mlp221_pkg::sigm(mlp221_pkg::sat16(acc_r1));
   end

   // Select operands for the shared multiplier
   always_comb begin
      op_a     = '0;
      op_b     = '0;
      mac_ctrl = '{enable: busy, accumulate: 1'b0};
      case (step_ff)
         mlp221_pkg::ST_H0_X0: begin
            op_a = OPA_W'(x0_ff); op_b = OPB_W'(wh_ff[0]);
         end
         mlp221_pkg::ST_H0_X1: begin
            op_a = OPA_W'(x1_ff); op_b = OPB_W'(wh_ff[2]); mac_ctrl.accumulate = 1'b1;
         end
         mlp221_pkg::ST_H0_B: begin
            op_a = OPA_W'(bh_ff[0]); op_b = OPB_W'(mlp221_pkg::UNIT);
            mac_ctrl.accumulate = 1'b1;
         end
         mlp221_pkg::ST_H1_X0: begin
            op_a = OPA_W'(x0_ff); op_b = OPB_W'(wh_ff[1]);
         end
         mlp221_pkg::ST_H1_X1: begin
            op_a = OPA_W'(x1_ff); op_b = OPB_W'(wh_ff[3]); mac_ctrl.accumulate = 1'b1;
         end
         mlp221_pkg::ST_H1_B: begin
            op_a = OPA_W'(bh_ff[1]); op_b = OPB_W'(mlp221_pkg::UNIT);
            mac_ctrl.accumulate = 1'b1;
         end
         mlp221_pkg::ST_Y_H0: begin
            op_a = OPA_W'(wo_ff[0]); op_b = OPB_W'({4'b0000, h0_ff});
         end
         mlp221_pkg::ST_Y_H1: begin
            op_a = OPA_W'(wo_ff[1]); op_b = OPB_W'({4'b0000, h1_ff});
            mac_ctrl.accumulate = 1'b1;
         end
         mlp221_pkg::ST_Y_B: begin
            op_a = OPA_W'(bo_ff); op_b = OPB_W'(mlp221_pkg::UNIT);
            mac_ctrl.accumulate = 1'b1;
         end
         mlp221_pkg::ST_LOSS: begin
            op_a = OPA_W'(d_w); op_b = OPB_W'(d_w);
         end
         mlp221_pkg::ST_DY: begin
            op_a = OPA_W'(d_w); op_b = OPB_W'({4'b0000, y_ff});
         end
         mlp221_pkg::ST_DYY: begin
            op_a = acc[OPA_W-1:0];
            op_b = OPB_W'(14'(mlp221_pkg::UNIT) - 14'($signed({1'b0, y_ff})));
         end
         mlp221_pkg::ST_WD0: begin
            op_a = OPA_W'(wo_ff[0]); op_b = OPB_W'(dout_ff);
         end
         mlp221_pkg::ST_LRDO: begin
            op_a = OPA_W'(dout_ff); op_b = OPB_W'({4'b0000, lr_ff});
         end
         mlp221_pkg::ST_DH0_A: begin
            op_a = OPA_W'(wd_ff); op_b = OPB_W'({4'b0000, h0_ff});
         end
         mlp221_pkg::ST_DH0_B: begin
            op_a = acc[OPA_W-1:0];
            op_b = OPB_W'(14'(mlp221_pkg::UNIT) - 14'($signed({1'b0, h0_ff})));
         end
         mlp221_pkg::ST_WD1: begin
            op_a = OPA_W'(wo_ff[1]); op_b = OPB_W'(dout_ff);
         end
         mlp221_pkg::ST_UWO0: begin
            op_a = lrd_ff; op_b = OPB_W'({4'b0000, h0_ff});
         end
         mlp221_pkg::ST_DH1_A: begin
            op_a = OPA_W'(wd_ff); op_b = OPB_W'({4'b0000, h1_ff});
         end
         mlp221_pkg::ST_DH1_B: begin
            op_a = acc[OPA_W-1:0];
            op_b = OPB_W'(14'(mlp221_pkg::UNIT) - 14'($signed({1'b0, h1_ff})));
         end
         mlp221_pkg::ST_UWO1: begin
            op_a = lrd_ff; op_b = OPB_W'({4'b0000, h1_ff});
         end
         mlp221_pkg::ST_LRDH0: begin
            op_a = OPA_W'(dh0_ff); op_b = OPB_W'({4'b0000, lr_ff});
         end
         mlp221_pkg::ST_UWH0: begin
            op_a = lrd_ff; op_b = OPB_W'(x0_ff);
         end
         mlp221_pkg::ST_UWH2: begin
            op_a = lrd_ff; op_b = OPB_W'(x1_ff);
         end
         mlp221_pkg::ST_LRDH1: begin
            op_a = OPA_W'(dh1_ff); op_b = OPB_W'({4'b0000, lr_ff});
         end
         mlp221_pkg::ST_UWH1: begin
            op_a = lrd_ff; op_b = OPB_W'(x0_ff);
         end
         mlp221_pkg::ST_UWH3: begin
            op_a = lrd_ff; op_b = OPB_W'(x1_ff);
         end
         default: begin
            mac_ctrl.enable = 1'b0;
         end
      endcase
   end

   mlp221_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // Sequence control: advance one step a cycle, drop back to idle when done
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mlp221_pkg::SEQ_IDLE;
         step_ff       <= mlp221_pkg::ST_H0_X0;
         rsp_strobe_ff <= 1'b0;
         lr_ff         <= 13'd410;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            lr_ff <= csr_data;
         end
         case (state_ff)
            mlp221_pkg::SEQ_IDLE: begin
               step_ff <= mlp221_pkg::ST_H0_X0;
               if (accept) begin
                  if (req_action == mlp221_pkg::ACT_LOAD) begin
                     rsp_strobe_ff <= 1'b1;
                  end else begin
                     state_ff <= mlp221_pkg::SEQ_RUN;
                  end
               end
            end
            mlp221_pkg::SEQ_RUN: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == mlp221_pkg::ST_DY) begin
                  rsp_strobe_ff <= 1'b1;
                  if (!train_ff) begin
                     state_ff <= mlp221_pkg::SEQ_IDLE;
                  end
               end
               if (step_ff == mlp221_pkg::ST_LAST) begin
                  state_ff <= mlp221_pkg::SEQ_IDLE;
               end
            end
            default: begin
               state_ff <= mlp221_pkg::SEQ_IDLE;
            end
         endcase
      end
   end

   // Weights: load on request, update during the backward pass
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            wh_ff[i] <= '0;
         end
         for (int j = 0; j < 2; j++) begin
            bh_ff[j] <= '0;
            wo_ff[j] <= '0;
         end
         bo_ff <= '0;
      end else if (accept && (req_action == mlp221_pkg::ACT_LOAD)) begin
         if (req_weight_index < 4'd4) begin
            wh_ff[req_weight_index[1:0]] <= req_weight_value;
         end else if (req_weight_index < 4'd6) begin
            bh_ff[req_weight_index[0]] <= req_weight_value;
         end else if (req_weight_index < 4'd8) begin
            wo_ff[req_weight_index[0]] <= req_weight_value;
         end else if (req_weight_index == 4'd8) begin
            bo_ff <= req_weight_value;
         end
      end else if (busy && train_ff) begin
         case (step_ff)
            mlp221_pkg::ST_DH1_A: wo_ff[0] <= mlp221_pkg::sat16(ACC_W'(wo_ff[0]) - acc_r2);
            mlp221_pkg::ST_LRDH0: begin
               wo_ff[1] <= mlp221_pkg::sat16(ACC_W'(wo_ff[1]) - acc_r2);
               bo_ff    <= mlp221_pkg::sat16(ACC_W'(bo_ff)
                           - mlp221_pkg::rnd(ACC_W'(lrd_ff), mlp221_pkg::SH_ONE));
            end
            mlp221_pkg::ST_BH0:  bh_ff[0] <= mlp221_pkg::sat16(ACC_W'(bh_ff[0]) - acc_r1);
            mlp221_pkg::ST_UWH2: wh_ff[0] <= mlp221_pkg::sat16(ACC_W'(wh_ff[0]) - acc_r2);
            mlp221_pkg::ST_LRDH1: wh_ff[2] <= mlp221_pkg::sat16(ACC_W'(wh_ff[2]) - acc_r2);
            mlp221_pkg::ST_BH1:  bh_ff[1] <= mlp221_pkg::sat16(ACC_W'(bh_ff[1]) - acc_r1);
            mlp221_pkg::ST_UWH3: wh_ff[1] <= mlp221_pkg::sat16(ACC_W'(wh_ff[1]) - acc_r2);
            mlp221_pkg::ST_LAST: wh_ff[3] <= mlp221_pkg::sat16(ACC_W'(wh_ff[3]) - acc_r2);
            default: begin
            end
         endcase
      end
   end

   // Capture inputs and intermediate values as the sequence produces them
   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff    <= req_input_a;
         x1_ff    <= req_input_b;
         t_ff     <= req_target;
         train_ff <= (req_action == mlp221_pkg::ACT_TRAIN);
      end
      if (accept && (req_action == mlp221_pkg::ACT_LOAD)) begin
         rsp_prediction_ff <= '0;
         rsp_error_loss_ff <= '0;
      end
      if (busy) begin
         case (step_ff)
            mlp221_pkg::ST_H1_X0: h0_ff <= acc_sig;
            mlp221_pkg::ST_Y_H0:  h1_ff <= acc_sig;
            mlp221_pkg::ST_Y_ACT: y_ff  <= acc_sig;
            mlp221_pkg::ST_DY: begin
               rsp_prediction_ff <= y_ff;
               rsp_error_loss_ff <= acc_rl[11:0];
            end
            mlp221_pkg::ST_DOUT:  dout_ff <= acc_r2[15:0];
            mlp221_pkg::ST_LRDO:  wd_ff   <= acc_r1[15:0];
            mlp221_pkg::ST_DH0_A: lrd_ff  <= acc[OPA_W-1:0];
            mlp221_pkg::ST_WD1:   dh0_ff  <= acc_r2[15:0];
            mlp221_pkg::ST_UWO0:  wd_ff   <= acc_r1[15:0];
            mlp221_pkg::ST_UWO1:  dh1_ff  <= acc_r2[15:0];
            mlp221_pkg::ST_BH0:   lrd_ff  <= acc[OPA_W-1:0];
            mlp221_pkg::ST_BH1:   lrd_ff  <= acc[OPA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_prediction = rsp_prediction_ff;
   assign rsp_error_loss = rsp_error_loss_ff;

endmodule

`default_nettype wire

>>> test/mlp_two_two_one_sgd_train_tb.sv
// Self-checking testbench for the 2-2-1 sigmoid network trainer.
// Predicts every result with its own fixed-point model of the network; needs mlp221_pkg.
// Drives random load, infer and train transactions with random gaps and learning rates.
`default_nettype none

module mlp_two_two_one_sgd_train_tb;

   typedef struct {
      logic [1:0]         action;
      logic signed [15:0] input_a;
      logic signed [15:0] input_b;
      logic               target;
      logic [3:0]         weight_index;
      logic signed [15:0] weight_value;
   } net_request_type;

   typedef struct {
      logic [12:0] prediction;
      logic [11:0] error_loss;
   } net_result_type;

   // Network predictor and store of expected results
   class net_scoreboard;
      longint             sig_lut [mlp221_pkg::SIGMOID_ENTRIES];
      longint             step_size;
      longint             wh [4];
      longint             bh [2];
      longint             wo [2];
      longint             bo;
      net_result_type     expected_q [$];
      int                 fail_count;

      function new();
         longint unsigned one, mid, p, m, a, u, t2, t3, t4, e, den, num;
         logic            pos;
         one = 64'd1 << 30;
         mid = 64'd1 << 39;
         for (int k = 0; k < mlp221_pkg::SIGMOID_ENTRIES; k++) begin
            p   = (64'(2 * k + 1) << 39) / mlp221_pkg::SIGMOID_ENTRIES;
            pos = p >= mid;
            m   = pos ? p - mid : mid - p;
            a   = m >> mlp221_pkg::FRACTION_BITS;
            u   = (a >> 10) << 6;
            t2  = (u * u) >> 30;
            t3  = (t2 * u) >> 30;
            t4  = (t3 * u) >> 30;
            e   = (one + t2 / 2 + t4 / 24) - u - t3 / 6;
            for (int r = 0; r < 10; r++) e = (e * e + (one >> 1)) >> 30;
            den = one + e;
            num = pos ? ((64'd1 << mlp221_pkg::FRACTION_BITS) << 30)
                      : (e << mlp221_pkg::FRACTION_BITS);
            sig_lut[k] = longint'((num + den / 2) / den);
         end
         step_size = 410;
         foreach (wh[i]) wh[i] = 0;
         foreach (bh[i]) begin
            bh[i] = 0;
            wo[i] = 0;
         end
         bo = 0;
         fail_count = 0;
      endfunction

      // Round half away from zero
      function longint round_off(longint v, int s);
         longint half;
         half = longint'(1) <<< (s - 1);
         if (v >= 0) return (v + half) >>> s;
         return -((-v + half) >>> s);
      endfunction

      function longint clamp16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint squash(longint s);
         longint idx;
         idx = ((clamp16(s) + 32768) * mlp221_pkg::SIGMOID_ENTRIES) >>> 16;
         if (idx >= mlp221_pkg::SIGMOID_ENTRIES) idx = mlp221_pkg::SIGMOID_ENTRIES - 1;
         return sig_lut[idx];
      endfunction

      function void set_step(logic [12:0] v);
         step_size = v;
      endfunction

      // Note an accepted transaction: compute its result and update the weights
      function void note_request(net_request_type rq);
         longint         unit, x [2], t, h [2], acc, y, d, dout, dh [2], wd;
         int             fb;
         net_result_type res;
         fb   = mlp221_pkg::FRACTION_BITS;
         unit = 1 << fb;
         if (rq.action == mlp221_pkg::ACT_LOAD) begin
            case (rq.weight_index)
               0, 1, 2, 3: wh[rq.weight_index] = rq.weight_value;
               4, 5:       bh[rq.weight_index - 4] = rq.weight_value;
               6, 7:       wo[rq.weight_index - 6] = rq.weight_value;
               8:          bo = rq.weight_value;
               default:    ;
            endcase
            res.prediction = '0;
            res.error_loss = '0;
            expected_q.push_back(res);
            return;
         end
         x[0] = rq.input_a;
         x[1] = rq.input_b;
         t = rq.target;
         for (int j = 0; j < 2; j++) begin
            acc  = x[0] * wh[j] + x[1] * wh[2 + j] + bh[j] * unit;
            h[j] = squash(clamp16(round_off(acc, fb)));
         end
         acc = h[0] * wo[0] + h[1] * wo[1] + bo * unit;
         y   = squash(clamp16(round_off(acc, fb)));
         d   = y - t * unit;
         res.prediction = 13'(y);
         res.error_loss = 12'(round_off(d * d, fb + 1));
         expected_q.push_back(res);
         if (rq.action != mlp221_pkg::ACT_TRAIN) return;
         // Backpropagate from the weights before the update
         dout = round_off(d * y * (unit - y), 2 * fb);
         for (int j = 0; j < 2; j++) begin
            wd    = round_off(wo[j] * dout, fb);
            dh[j] = round_off(wd * h[j] * (unit - h[j]), 2 * fb);
         end
         for (int j = 0; j < 2; j++)
            wo[j] = clamp16(wo[j] - round_off(step_size * dout * h[j], 2 * fb));
         bo = clamp16(bo - round_off(step_size * dout, fb));
         for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++)
               wh[2 * i + j] = clamp16(wh[2 * i + j]
                                 - round_off(step_size * dh[j] * x[i], 2 * fb));
            bh[j] = clamp16(bh[j] - round_off(step_size * dh[j], fb));
         end
      endfunction

      // Compare a result against the oldest expectation
      function void check_result(logic [12:0] prediction, logic [11:0] error_loss);
         net_result_type exp_res;
         if (expected_q.size() == 0) begin
            $error("unexpected result: prediction %0d error_loss %0d", prediction, error_loss);
            fail_count++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (prediction !== exp_res.prediction) begin
            $error("prediction: expected %0d, actual %0d", exp_res.prediction, prediction);
            fail_count++;
         end
         if (error_loss !== exp_res.error_loss) begin
            $error("error_loss: expected %0d, actual %0d", exp_res.error_loss, error_loss);
            fail_count++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_action = mlp221_pkg::ACT_LOAD;
   logic signed [15:0] req_input_a = '0;
   logic signed [15:0] req_input_b = '0;
   logic               req_target = 1'b0;
   logic [3:0]         req_weight_index = '0;
   logic signed [15:0] req_weight_value = '0;
   logic               rsp_strobe;
   logic [12:0]        rsp_prediction;
   logic [11:0]        rsp_error_loss;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [12:0]        csr_data = '0;

   net_scoreboard scoreboard = new();
   bit            use_gaps = 1'b1;

   mlp_two_two_one_sgd_train dut (
      .clock, .reset, .start, .busy,
      .req_action, .req_input_a, .req_input_b, .req_target,
      .req_weight_index, .req_weight_value,
      .rsp_strobe, .rsp_prediction, .rsp_error_loss,
      .csr_valid, .csr_ready, .csr_data
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watch all three channels at the edge that completes each transaction
   always @(posedge clock) begin
      net_request_type rq;
      if (!reset) begin
         if (csr_valid && csr_ready) scoreboard.set_step(csr_data);
         if (start && !busy) begin
            rq.action       = req_action;
            rq.input_a      = req_input_a;
            rq.input_b      = req_input_b;
            rq.target       = req_target;
            rq.weight_index = req_weight_index;
            rq.weight_value = req_weight_value;
            scoreboard.note_request(rq);
         end
         if (rsp_strobe) scoreboard.check_result(rsp_prediction, rsp_error_loss);
      end
   end

   // Present one transaction and hold it until accepted, then maybe idle
   task automatic send_request(net_request_type rq);
      start            <= 1'b1;
      req_action       <= rq.action;
      req_input_a      <= rq.input_a;
      req_input_b      <= rq.input_b;
      req_target       <= rq.target;
      req_weight_index <= rq.weight_index;
      req_weight_value <= rq.weight_value;
      do @(posedge clock); while (busy);
      if (use_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Drain outstanding results and the trailing weight updates
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (scoreboard.expected_q.size() != 0 || busy) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_step(logic [12:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_word();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 16384)) - 8192);
   endfunction

   function automatic net_request_type make_load(logic [3:0] idx, logic signed [15:0] val);
      net_request_type rq;
      rq = '{mlp221_pkg::ACT_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), idx, val};
      return rq;
   endfunction

   function automatic net_request_type make_run(logic [1:0] act, logic signed [15:0] a,
                                                 logic signed [15:0] b, logic tgt);
      net_request_type rq;
      rq = '{act, a, b, tgt, 4'($urandom), 16'($urandom)};
      return rq;
   endfunction

   // Random mix: mostly infer and train, some loads and noise
   task automatic random_phase(int count);
      int              sel;
      net_request_type rq;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 15)
            rq = make_load($urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 8)),
                           pick_word());
         else if (sel < 50)
            rq = make_run(mlp221_pkg::ACT_INFER, pick_word(), pick_word(), 1'($urandom));
         else if (sel < 95)
            rq = make_run(mlp221_pkg::ACT_TRAIN, pick_word(), pick_word(), 1'($urandom));
         else
            rq = make_run(mlp221_pkg::ACT_RESERVED, pick_word(), pick_word(), 1'($urandom));
         send_request(rq);
      end
   endtask

   initial begin
      logic [12:0] steps [5];
      steps = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'd410};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme loads, every action, both targets, ignored index
      send_request(make_run(mlp221_pkg::ACT_INFER, 16'sh7FFF, -16'sh8000, 1'b1));
      send_request(make_run(mlp221_pkg::ACT_TRAIN, 16'sh1000, 16'sh1000, 1'b1));
      for (int i = 0; i < 9; i++)
         send_request(make_load(4'(i), (i % 2) ? -16'sh8000 : 16'sh7FFF));
      send_request(make_load(4'd15, 16'sh1234));
      send_request(make_load(4'd9, 16'shFFFF));
      send_request(make_run(mlp221_pkg::ACT_INFER, 16'sh7FFF, 16'sh7FFF, 1'b0));
      send_request(make_run(mlp221_pkg::ACT_INFER, -16'sh8000, -16'sh8000, 1'b1));
      send_request(make_run(mlp221_pkg::ACT_RESERVED, 16'sh0800, -16'sh0800, 1'b1));
      send_request(make_run(mlp221_pkg::ACT_TRAIN, 16'sh7FFF, -16'sh8000, 1'b0));
      send_request(make_run(mlp221_pkg::ACT_TRAIN, -16'sh8000, 16'sh7FFF, 1'b1));
      for (int i = 0; i < 9; i++) send_request(make_load(4'(i), 16'sh0000));
      send_request(make_run(mlp221_pkg::ACT_TRAIN, 16'sh0000, 16'sh0000, 1'b1));
      wait_idle();

      // Random phases across learning rates, extremes included
      foreach (steps[s]) begin
         write_step(steps[s]);
         random_phase(180);
         wait_idle();
      end
      write_step(13'($urandom_range(0, 4096)));
      random_phase(200);
      use_gaps = 1'b0;
      random_phase(120);
      wait_idle();

      if (scoreboard.fail_count == 0 && scoreboard.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard limit on run time
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

>>> mlp_two_two_one_sgd_train.f
rtl/mlp221_pkg.sv
rtl/mlp221_mac.sv
rtl/mlp_two_two_one_sgd_train.sv
test/mlp_two_two_one_sgd_train_tb.sv
